// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication checked in the following cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/ntt_pkg.sv -----
`timescale 1ns / 1ps
package ntt_pkg;
    localparam int TableEntriesDefault = 8;
    localparam int IdW = 15;
    localparam int WeightW = 24;
    localparam int DamageW = 16;
    localparam int TrafficW = 15;
    localparam int VisitW = 16;
    localparam int SumW = 32;
    localparam int AvgW = 24;
    localparam logic [WeightW-1:0] CampLimitReset = 24'd98304;
    localparam logic [WeightW-1:0] WeightMax = 24'hFFFFFF;
    localparam logic [TrafficW-1:0] TrafficMax = 15'h7FFF;

    typedef enum logic [2:0] {
        OP_SET = 3'd0,
        OP_ADD_TRAFFIC = 3'd1,
        OP_GET = 3'd2,
        OP_DELETE = 3'd3,
        OP_ADD_DAMAGE = 3'd4,
        OP_READ_DAMAGE = 3'd5
    } op_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;       // capture input beat
        logic scan_clr;   // reset scan pointer
        logic scan_step;  // advance scan pointer
        logic write_set;  // set at scan pointer
        logic write_add;  // add traffic at scan pointer (no mean)
        logic div_start;  // start divider
        logic mean_write; // write mean result at hit slot
        logic shift_step; // move entry up one slot
        logic clear_last; // clear last slot
        logic add_damage;
        logic visit_inc;
        logic finish;     // drive result
    } ctrl_t;

    // datapath status to controller
    typedef struct packed {
        logic hit;        // entry at pointer matches
        logic empty;      // entry at pointer is empty
        logic scan_last;  // pointer at last slot
        logic div_done;
        logic mean_need;  // weight below camp limit
    } stat_t;
endpackage

// ----- rtl/ntt_divider.sv -----
`timescale 1ns / 1ps
module ntt_divider (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [ntt_pkg::SumW-1:0] dividend,
    input  logic [ntt_pkg::VisitW:0] divisor,
    output logic                    done,
    output logic [ntt_pkg::SumW-1:0] quotient
);
    import ntt_pkg::*;

    localparam int CntW = $clog2(SumW + 1);

    logic [SumW-1:0] quot_reg, quot_next;
    logic [VisitW+1:0] rem_reg, rem_next;
    logic [VisitW:0] dvs_reg;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic busy_reg, busy_next, done_reg, done_next;
    logic [VisitW+1:0] trial;

    // restoring division, one quotient bit a cycle
    always_comb
    begin
        quot_next = quot_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {rem_reg[VisitW:0], quot_reg[SumW-1]};
        if (start)
        begin
            quot_next = dividend;
            rem_next = '0;
            cnt_next = CntW'(SumW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quot_next = {quot_reg[SumW-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quot_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done = done_reg;
    assign quotient = quot_reg;
endmodule

// ----- rtl/ntt_datapath.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntt_datapath #(
    parameter int TABLE_ENTRIES = ntt_pkg::TableEntriesDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ntt_pkg::ctrl_t              ctrl,
    output ntt_pkg::stat_t              stat,
    input  logic                        cfg_we,
    input  logic [ntt_pkg::WeightW-1:0] cfg_data,
    input  logic [2:0]                  op_in,
    input  logic [ntt_pkg::IdW-1:0]     id_in,
    input  logic [ntt_pkg::WeightW-1:0] weight_in,
    input  logic [ntt_pkg::DamageW-1:0] damage_in,
    input  logic                        ok_in,
    output logic                        done,
    output logic                        ok,
    output logic signed [15:0]          traffic_out,
    output logic [ntt_pkg::AvgW-1:0]    avg_damage
);
    import ntt_pkg::*;

    localparam int PtrW = $clog2(TABLE_ENTRIES);

    logic [IdW:0] ids_reg [TABLE_ENTRIES];
    logic [WeightW-1:0] wts_reg [TABLE_ENTRIES];
    logic [TrafficW-1:0] trf_reg [TABLE_ENTRIES];
    logic [VisitW-1:0] visit_reg;
    logic [SumW-1:0] dsum_reg;
    logic [WeightW-1:0] camp_reg;
    logic [2:0] op_reg;
    logic [IdW-1:0] id_reg;
    logic [WeightW-1:0] wt_reg;
    logic [DamageW-1:0] dmg_reg;
    logic [PtrW-1:0] ptr_reg;
    logic done_reg, ok_reg;
    logic [15:0] trf_out_reg;
    logic [AvgW-1:0] avg_reg;
    logic [WeightW-1:0] diff;
    logic up;
    logic [TrafficW-1:0] trf_cur, trf_inc;
    logic [SumW-1:0] div_a;
    logic [VisitW:0] div_b;
    logic div_done;
    logic [SumW-1:0] div_q;
    logic [SumW:0] dsum_add;
    logic [WeightW-1:0] mean_w;

    assign trf_cur = trf_reg[ptr_reg];
    assign trf_inc = (trf_cur == TrafficMax) ? trf_cur : trf_cur + 1'b1;
    assign up = wt_reg >= wts_reg[ptr_reg];
    assign diff = up ? wt_reg - wts_reg[ptr_reg] : wts_reg[ptr_reg] - wt_reg;

    // running mean divides |diff| by traffic+1, damage read by visit count
    always_comb
    begin
        if (op_reg == OP_READ_DAMAGE)
        begin
            div_a = dsum_reg;
            div_b = {1'b0, visit_reg};
        end
        else
        begin
            div_a = SumW'(diff);
            div_b = (VisitW+1)'(trf_cur) + 1'b1;
        end
    end

    ntt_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(ctrl.div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done), .quotient(div_q)
    );

    assign mean_w = up ? wts_reg[ptr_reg] + div_q[WeightW-1:0]
                       : wts_reg[ptr_reg] - div_q[WeightW-1:0];
    assign dsum_add = {1'b0, dsum_reg} + (SumW+1)'(dmg_reg);

    assign stat.hit = ids_reg[ptr_reg] == {1'b0, id_reg};
    assign stat.empty = ids_reg[ptr_reg][IdW];
    assign stat.scan_last = ptr_reg == PtrW'(TABLE_ENTRIES - 1);
    assign stat.div_done = div_done;
    assign stat.mean_need = wt_reg < camp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
            begin
                ids_reg[i] <= {1'b1, {IdW{1'b0}}};
                wts_reg[i] <= WeightMax;
                trf_reg[i] <= '0;
            end
            visit_reg <= '0;
            dsum_reg <= '0;
            camp_reg <= CampLimitReset;
            ptr_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctrl.finish;
            if (cfg_we)
                camp_reg <= cfg_data;
            if (ctrl.scan_clr)
                ptr_reg <= '0;
            else if (ctrl.scan_step)
                ptr_reg <= ptr_reg + 1'b1;
            if (ctrl.write_set)
            begin
                ids_reg[ptr_reg] <= {1'b0, id_reg};
                wts_reg[ptr_reg] <= wt_reg;
            end
            if (ctrl.write_add)
            begin
                trf_reg[ptr_reg] <= trf_inc;
                if (stat.empty)
                begin
                    ids_reg[ptr_reg] <= {1'b0, id_reg};
                    wts_reg[ptr_reg] <= wt_reg;
                end
            end
            if (ctrl.mean_write)
                wts_reg[ptr_reg] <= mean_w;
            if (ctrl.shift_step)
            begin
                ids_reg[ptr_reg] <= ids_reg[ptr_reg + 1'b1];
                wts_reg[ptr_reg] <= wts_reg[ptr_reg + 1'b1];
                trf_reg[ptr_reg] <= trf_reg[ptr_reg + 1'b1];
            end
            if (ctrl.clear_last)
            begin
                ids_reg[TABLE_ENTRIES-1] <= {1'b1, {IdW{1'b0}}};
                wts_reg[TABLE_ENTRIES-1] <= WeightMax;
                trf_reg[TABLE_ENTRIES-1] <= '0;
            end
            if (ctrl.visit_inc && visit_reg != {VisitW{1'b1}})
                visit_reg <= visit_reg + 1'b1;
            if (ctrl.add_damage)
                dsum_reg <= dsum_add[SumW] ? {SumW{1'b1}} : dsum_add[SumW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            op_reg <= op_in;
            id_reg <= id_in;
            wt_reg <= weight_in;
            dmg_reg <= damage_in;
        end
        if (ctrl.finish)
        begin
            ok_reg <= ok_in;
            if (op_reg == OP_GET)
                trf_out_reg <= ok_in ? {1'b0, trf_cur} : 16'hFFFF;
            else
                trf_out_reg <= '0;
            if (op_reg == OP_READ_DAMAGE && visit_reg != '0)
                avg_reg <= (div_q > SumW'(WeightMax)) ? WeightMax : div_q[AvgW-1:0];
            else
                avg_reg <= '0;
        end
    end

    assign done = done_reg;
    assign ok = done_reg & ok_reg;
    assign traffic_out = done_reg ? trf_out_reg : 16'sd0;
    assign avg_damage = done_reg ? avg_reg : '0;

    `ASSERT_IMPL(a_one_write, clk, rst_n, ctrl.shift_step, !ctrl.write_set && !ctrl.write_add)
    `ASSERT_IMPL(a_div_mean, clk, rst_n, ctrl.mean_write, !ctrl.div_start)
    `ASSERT_NEXT(a_done_follows, clk, rst_n, ctrl.finish, done)
endmodule

// ----- rtl/ntt_ctrl.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2:0]     op,
    output logic           busy,
    output logic           ok_res,
    output ntt_pkg::ctrl_t ctrl,
    input  ntt_pkg::stat_t stat
);
    import ntt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_DIV, S_MEAN, S_SHIFT, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic [2:0] op_reg, op_next;
    logic ok_reg, ok_next;

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        ok_next = ok_reg;
        ctrl = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load = 1'b1;
                    ctrl.scan_clr = 1'b1;
                    op_next = op;
                    ok_next = 1'b0;
                    state_next = S_SCAN;
                    if (op == OP_ADD_TRAFFIC)
                        ctrl.visit_inc = 1'b1;
                end
            end
            S_SCAN:
            begin
                case (op_reg)
                    OP_SET:
                    begin
                        if (stat.hit || stat.empty)
                        begin
                            ctrl.write_set = 1'b1;
                            ok_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (stat.scan_last)
                            state_next = S_DONE;
                        else
                            ctrl.scan_step = 1'b1;
                    end
                    OP_ADD_TRAFFIC:
                    begin
                        if (stat.hit || stat.empty)
                        begin
                            ctrl.write_add = 1'b1;
                            ok_next = 1'b1;
                            if (stat.hit && stat.mean_need)
                            begin
                                state_next = S_DIV;
                            end
                            else
                                state_next = S_DONE;
                        end
                        else if (stat.scan_last)
                            state_next = S_DONE;
                        else
                            ctrl.scan_step = 1'b1;
                    end
                    OP_GET:
                    begin
                        if (stat.hit)
                        begin
                            ok_next = 1'b1;
                            state_next = S_DONE;
                        end
                        else if (stat.scan_last)
                            state_next = S_DONE;
                        else
                            ctrl.scan_step = 1'b1;
                    end
                    OP_DELETE:
                    begin
                        if (stat.hit)
                        begin
                            ok_next = 1'b1;
                            state_next = S_SHIFT;
                        end
                        else if (stat.scan_last)
                            state_next = S_DONE;
                        else
                            ctrl.scan_step = 1'b1;
                    end
                    OP_ADD_DAMAGE:
                    begin
                        ctrl.add_damage = 1'b1;
                        ok_next = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_READ_DAMAGE:
                    begin
                        ctrl.div_start = 1'b1;
                        ok_next = 1'b1;
                        state_next = S_MEAN;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_DIV:
            begin
                // traffic already updated, divisor is new traffic + 1
                ctrl.div_start = 1'b1;
                state_next = S_MEAN;
            end
            S_MEAN:
            begin
                if (stat.div_done)
                begin
                    if (op_reg == OP_ADD_TRAFFIC)
                        ctrl.mean_write = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (stat.scan_last)
                begin
                    ctrl.clear_last = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ctrl.shift_step = 1'b1;
                    ctrl.scan_step = 1'b1;
                end
            end
            S_DONE:
            begin
                ctrl.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg <= '0;
            ok_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            ok_reg <= ok_next;
        end
    end

    assign busy = state_reg != S_IDLE;
    assign ok_res = ok_reg;

    `ASSERT_NEXT(a_start_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPL(a_finish_done, clk, rst_n, ctrl.finish, state_reg == S_DONE)
    `ASSERT_IMPL(a_mean_op, clk, rst_n, ctrl.mean_write, op_reg == OP_ADD_TRAFFIC)
endmodule

// ----- rtl/neighbour_traffic_table.sv -----
`timescale 1ns / 1ps
// neighbour traffic table: ordered table of neighbour id, weight and traffic
// command channel: drive op and fields with start; a beat is taken when
// start is high and busy is low, and busy stays high until the result
// result channel: done pulses one cycle with ok, traffic_out, avg_damage;
// all result fields read zero outside that cycle, the receiver cannot stall
// config: camp_limit is written when camp_limit_we is high; the user must
// write it only while idle, the block itself does not enforce this
// sequencing: a table scan visits one slot per cycle; set and get scan, and
// delete of a present id scans and then shifts the entries after it; running
// mean and damage read use a one-bit-per-cycle divider of 32 steps, so add
// traffic with a mean update scans and then divides, and a damage read only
// divides; add damage updates the sum; one beat is in flight at a time
// reset: table entries empty, weights all ones, counters zero,
// camp_limit back to 1.5 in Q8.16
module neighbour_traffic_table #(
    parameter int TABLE_ENTRIES = ntt_pkg::TableEntriesDefault
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [2:0]                  op,
    input  logic [ntt_pkg::IdW-1:0]     neighbour_id,
    input  logic [ntt_pkg::WeightW-1:0] weight_in,
    input  logic [ntt_pkg::DamageW-1:0] damage_in,
    input  logic                        camp_limit_we,
    input  logic [ntt_pkg::WeightW-1:0] camp_limit,
    output logic                        done,
    output logic                        ok,
    output logic signed [15:0]          traffic_out,
    output logic [ntt_pkg::AvgW-1:0]    avg_damage
);
    import ntt_pkg::*;

    ctrl_t ctrl;
    stat_t stat;
    logic ok_res;

    ntt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .op(op), .busy(busy),
        .ok_res(ok_res), .ctrl(ctrl), .stat(stat)
    );

    ntt_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
        .cfg_we(camp_limit_we), .cfg_data(camp_limit),
        .op_in(op), .id_in(neighbour_id), .weight_in(weight_in),
        .damage_in(damage_in), .ok_in(ok_res), .done(done), .ok(ok),
        .traffic_out(traffic_out), .avg_damage(avg_damage)
    );
endmodule

// ----- verif/neighbour_traffic_table_tb.sv -----
`timescale 1ns / 1ps
module neighbour_traffic_table_tb;
    import ntt_pkg::*;

    localparam int NumEntries = 8;
    localparam logic [15:0] EmptyId = 16'h8000;
    localparam int CycleLimit = 400000;
    localparam int DrainCycles = 80;

    typedef struct {
        logic ok;
        logic [15:0] traffic;
        logic [AvgW-1:0] avg;
    } outcome_t;

    typedef struct {
        logic [2:0] op;
        logic [IdW-1:0] id;
        logic [WeightW-1:0] wt;
        logic [DamageW-1:0] dmg;
        bit typed;
        outcome_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [2:0] op = '0;
    logic [IdW-1:0] neighbour_id = '0;
    logic [WeightW-1:0] weight_in = '0;
    logic [DamageW-1:0] damage_in = '0;
    logic camp_limit_we = 1'b0;
    logic [WeightW-1:0] camp_limit = '0;
    logic done;
    logic ok;
    logic signed [15:0] traffic_out;
    logic [AvgW-1:0] avg_damage;

    // shadow copy of the table
    logic [15:0] tbl_id [NumEntries];
    logic [WeightW-1:0] tbl_wt [NumEntries];
    logic [TrafficW-1:0] tbl_tr [NumEntries];
    logic [VisitW-1:0] visits;
    logic [SumW-1:0] dmg_sum;
    logic [WeightW-1:0] limit_shadow;

    outcome_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    row_t dir_rows[$];

    neighbour_traffic_table u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .op(op),
        .neighbour_id(neighbour_id), .weight_in(weight_in), .damage_in(damage_in),
        .camp_limit_we(camp_limit_we), .camp_limit(camp_limit), .done(done),
        .ok(ok), .traffic_out(traffic_out), .avg_damage(avg_damage)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("timeout");
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        errors++;
    endtask

    function automatic logic [WeightW-1:0] mean_toward(logic [WeightW-1:0] w,
            logic [WeightW-1:0] tgt, logic [TrafficW-1:0] t);
        logic [31:0] d;
        d = 32'(t) + 1;
        if (tgt >= w)
            return w + WeightW'((32'(tgt) - 32'(w)) / d);
        return w - WeightW'((32'(w) - 32'(tgt)) / d);
    endfunction

    task automatic clear_table();
        for (int i = 0; i < NumEntries; i++)
        begin
            tbl_id[i] = EmptyId;
            tbl_wt[i] = WeightMax;
            tbl_tr[i] = '0;
        end
        visits = '0;
        dmg_sum = '0;
        limit_shadow = CampLimitReset;
    endtask

    function automatic outcome_t table_step(logic [2:0] o, logic [IdW-1:0] id,
            logic [WeightW-1:0] wt, logic [DamageW-1:0] dmg);
        outcome_t r;
        logic [15:0] id16;
        logic [31:0] q;
        r.ok = 0;
        r.traffic = '0;
        r.avg = '0;
        id16 = {1'b0, id};
        case (o)
            OP_SET:
                for (int i = 0; i < NumEntries; i++)
                    if (tbl_id[i] == EmptyId || tbl_id[i] == id16)
                    begin
                        tbl_id[i] = id16;
                        tbl_wt[i] = wt;
                        r.ok = 1;
                        break;
                    end
            OP_ADD_TRAFFIC:
            begin
                if (visits != 16'hFFFF)
                    visits++;
                for (int i = 0; i < NumEntries; i++)
                begin
                    if (tbl_id[i] == id16)
                    begin
                        if (tbl_tr[i] != TrafficMax)
                            tbl_tr[i]++;
                        if (wt < limit_shadow)
                            tbl_wt[i] = mean_toward(tbl_wt[i], wt, tbl_tr[i]);
                        r.ok = 1;
                        break;
                    end
                    if (tbl_id[i] == EmptyId)
                    begin
                        if (tbl_tr[i] != TrafficMax)
                            tbl_tr[i]++;
                        tbl_id[i] = id16;
                        tbl_wt[i] = wt;
                        r.ok = 1;
                        break;
                    end
                end
            end
            OP_GET:
            begin
                r.traffic = 16'hFFFF;
                for (int i = 0; i < NumEntries; i++)
                    if (tbl_id[i] == id16)
                    begin
                        r.traffic = {1'b0, tbl_tr[i]};
                        r.ok = 1;
                        break;
                    end
            end
            OP_DELETE:
                for (int i = 0; i < NumEntries; i++)
                    if (tbl_id[i] == id16)
                    begin
                        for (int j = i; j + 1 < NumEntries; j++)
                        begin
                            tbl_id[j] = tbl_id[j+1];
                            tbl_wt[j] = tbl_wt[j+1];
                            tbl_tr[j] = tbl_tr[j+1];
                        end
                        tbl_id[NumEntries-1] = EmptyId;
                        tbl_wt[NumEntries-1] = WeightMax;
                        tbl_tr[NumEntries-1] = '0;
                        r.ok = 1;
                        break;
                    end
            OP_ADD_DAMAGE:
            begin
                if (dmg_sum > 32'hFFFFFFFF - 32'(dmg))
                    dmg_sum = 32'hFFFFFFFF;
                else
                    dmg_sum += 32'(dmg);
                r.ok = 1;
            end
            OP_READ_DAMAGE:
            begin
                if (visits != 0)
                begin
                    q = dmg_sum / 32'(visits);
                    r.avg = (q > 32'hFFFFFF) ? 24'hFFFFFF : q[23:0];
                end
                r.ok = 1;
            end
            default: ;
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                outcome_t e;
                e = pending_results.pop_front();
                if (ok !== e.ok)
                    report_mismatch($sformatf("ok %b want %b", ok, e.ok));
                if (traffic_out !== e.traffic)
                    report_mismatch($sformatf("traffic %h want %h", traffic_out, e.traffic));
                if (avg_damage !== e.avg)
                    report_mismatch($sformatf("avg %h want %h", avg_damage, e.avg));
            end
        end
    end

    // start stays high between beats sent back to back
    task automatic send_beat(logic [2:0] o, logic [IdW-1:0] id, logic [WeightW-1:0] wt,
            logic [DamageW-1:0] dmg, bit typed, outcome_t want);
        outcome_t p;
        int gap;
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        op <= o;
        neighbour_id <= id;
        weight_in <= wt;
        damage_in <= dmg;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        p = table_step(o, id, wt, dmg);
        if (typed && (p.ok !== want.ok || p.traffic !== want.traffic || p.avg !== want.avg))
            report_mismatch("directed row disagrees with predictor");
        pending_results.push_back(typed ? want : p);
    endtask

    task automatic drain_then_idle();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_limit(logic [WeightW-1:0] v);
        drain_then_idle();
        camp_limit_we <= 1'b1;
        camp_limit <= v;
        @(posedge clk);
        camp_limit_we <= 1'b0;
        limit_shadow = v;
    endtask

    function automatic row_t mk(logic [2:0] o, int id, int wt, int dmg, bit typed,
            logic k, logic [15:0] tr, logic [23:0] av);
        row_t r;
        r.op = o;
        r.id = IdW'(id);
        r.wt = WeightW'(wt);
        r.dmg = DamageW'(dmg);
        r.typed = typed;
        r.want.ok = k;
        r.want.traffic = tr;
        r.want.avg = av;
        return r;
    endfunction

    // ids drawn mostly from a small pool so entries hit, fill and delete
    function automatic logic [IdW-1:0] pick_id();
        if ($urandom_range(0, 9) < 8)
            return IdW'($urandom_range(0, 11)) ^ 15'h5A50;
        return IdW'($urandom);
    endfunction

    initial
    begin
        logic [2:0] o;
        logic [WeightW-1:0] w;
        logic [DamageW-1:0] dm;
        outcome_t none;
        none = '{0, 0, 0};
        clear_table();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // after reset: absent get, empty damage read, delete miss
        dir_rows.push_back(mk(OP_GET, 0, 0, 0, 1, 0, 16'hFFFF, 0));
        dir_rows.push_back(mk(OP_READ_DAMAGE, 0, 0, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(OP_DELETE, 32767, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(OP_SET, 32767, 16777214, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(OP_GET, 32767, 0, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(OP_ADD_TRAFFIC, 32767, 0, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(OP_GET, 32767, 0, 0, 1, 1, 1, 0));
        dir_rows.push_back(mk(OP_ADD_TRAFFIC, 0, 16777214, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_ADD_TRAFFIC, 0, 1000, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_ADD_DAMAGE, 0, 0, 65535, 1, 1, 0, 0));
        dir_rows.push_back(mk(OP_READ_DAMAGE, 0, 0, 0, 0, 0, 0, 0));
        // fill the table, then one more misses
        for (int i = 1; i <= 6; i++)
            dir_rows.push_back(mk(OP_SET, i, i * 4096, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_SET, 99, 5, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(OP_ADD_TRAFFIC, 99, 5, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(OP_DELETE, 0, 0, 0, 1, 1, 0, 0));
        dir_rows.push_back(mk(OP_GET, 1, 0, 0, 0, 0, 0, 0));
        dir_rows.push_back(mk(6, 1, 0, 0, 1, 0, 0, 0));
        dir_rows.push_back(mk(7, 32767, 16777214, 65535, 1, 0, 0, 0));
        foreach (dir_rows[i])
            send_beat(dir_rows[i].op, dir_rows[i].id, dir_rows[i].wt, dir_rows[i].dmg,
                dir_rows[i].typed, dir_rows[i].want);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: write_limit(24'hFFFFFF);
                1: write_limit(24'h000000);
                2: write_limit(WeightW'($urandom));
                default: write_limit(CampLimitReset);
            endcase
            for (int n = 0; n < 250; n++)
            begin
                case ($urandom_range(0, 19))
                    0, 1, 2: o = OP_SET;
                    3, 4, 5, 6, 7, 8: o = OP_ADD_TRAFFIC;
                    9, 10, 11: o = OP_GET;
                    12, 13: o = OP_DELETE;
                    14, 15: o = OP_ADD_DAMAGE;
                    16, 17: o = OP_READ_DAMAGE;
                    default: o = 3'($urandom_range(0, 7));
                endcase
                w = ($urandom_range(0, 1) == 0) ? WeightW'($urandom_range(0, 200000))
                    : WeightW'($urandom_range(0, 16777214));
                dm = DamageW'($urandom);
                send_beat(o, pick_id(), w, dm, 0, none);
                if (phase == 1 && n == 120)
                    drain_then_idle();
            end
        end

        drain_then_idle();
        if (errors == 0 && pending_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
